/* src/fpaic_pkg.sv */
// ----------------------------------------------------------------------------
// fpaic_pkg
// Shared constants and types for the fp32 add/multiply/convert pipeline.
// ----------------------------------------------------------------------------
package fpaic_pkg;

   localparam int unsigned FracBits = 23;
   localparam int unsigned ExpBits  = 8;
   localparam logic [ExpBits-1:0] Bias = 8'd127;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_MUL = 2'd1,
      MODE_CVT = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   // stage 1 -> stage 2: add/convert magnitude or full product
   typedef struct packed {
      mode_type    mode;
      logic        sign;
      logic [7:0]  exp;
      logic [31:0] mag;
      logic [47:0] prod;
   } s1_type;

   // stage 2 -> stage 3: value to normalise
   typedef struct packed {
      mode_type    mode;
      logic        sign;
      logic [7:0]  exp;
      logic [31:0] mag;
      logic        zero;
   } s2_type;

   // leading-one position of a 32-bit word (zero input gives 0)
   function automatic logic [4:0] lead_one(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

/* src/fpaic_front.sv */
// ----------------------------------------------------------------------------
// fpaic_front
// Stage 1: unpack, align and add, form product, magnitude for convert.
// ----------------------------------------------------------------------------
module fpaic_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  fpaic_pkg::mode_type in_mode,
   input  logic [31:0]         in_a,
   input  logic [31:0]         in_b,
   output logic                out_valid,
   output fpaic_pkg::s1_type   out_data
);
   logic [7:0]  ea, eb, d;
   logic [23:0] ma, mb, sa_m, sb_m;
   logic        a_big;
   fpaic_pkg::s1_type s1_in, s1_ff;
   logic        valid_ff;

   always_comb begin
      ea = in_a[30:23];
      eb = in_b[30:23];
      ma = {1'b1, in_a[22:0]};
      mb = {1'b1, in_b[22:0]};
      a_big = ea > eb;
      d = a_big ? (ea - eb) : (eb - ea);
      sa_m = ma;
      sb_m = mb;
      if (a_big) sb_m = (d >= 8'd24) ? '0 : (mb >> d);
      else       sa_m = (d >= 8'd24) ? '0 : (ma >> d);
      s1_in = '0;
      s1_in.mode = in_mode;
      unique case (in_mode)
         fpaic_pkg::MODE_ADD: begin
            s1_in.exp = a_big ? ea : eb;
            if (in_a[31] == in_b[31]) s1_in.mag = 32'(sa_m) + 32'(sb_m);
            else if (sa_m > sb_m)     s1_in.mag = 32'(sa_m - sb_m);
            else                      s1_in.mag = 32'(sb_m - sa_m);
            s1_in.sign = (sa_m > sb_m) ? in_a[31] : in_b[31];
         end
         fpaic_pkg::MODE_MUL: begin
            s1_in.sign = in_a[31] ^ in_b[31];
            s1_in.exp  = ea + eb - fpaic_pkg::Bias;
            s1_in.prod = 48'(ma) * 48'(mb);
         end
         fpaic_pkg::MODE_CVT: begin
            s1_in.sign = in_a[31];
            s1_in.mag  = in_a[31] ? (32'd0 - in_a) : in_a;
         end
         default: s1_in.mode = fpaic_pkg::MODE_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) s1_ff <= s1_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = s1_ff;
endmodule

/* src/fpaic_mid.sv */
// ----------------------------------------------------------------------------
// fpaic_mid
// Stage 2: normalise product, flag zero magnitudes.
// ----------------------------------------------------------------------------
module fpaic_mid (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  fpaic_pkg::s1_type in_data,
   output logic              out_valid,
   output fpaic_pkg::s2_type out_data
);
   fpaic_pkg::s2_type s2_in, s2_ff;
   logic valid_ff;

   always_comb begin
      s2_in.mode = in_data.mode;
      s2_in.sign = in_data.sign;
      s2_in.exp  = in_data.exp;
      s2_in.mag  = in_data.mag;
      s2_in.zero = (in_data.mag == '0);
      if (in_data.mode == fpaic_pkg::MODE_MUL) begin
         s2_in.zero = 1'b0;
         if (in_data.prod[47]) begin
            s2_in.mag = {9'd1, in_data.prod[46:24]};
            s2_in.exp = in_data.exp + 8'd1;
         end else begin
            s2_in.mag = {9'd1, in_data.prod[45:23]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) s2_ff <= s2_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = s2_ff;
endmodule

/* src/fpaic_back.sv */
// ----------------------------------------------------------------------------
// fpaic_back
// Stage 3: leading-one search, shift and pack.
// ----------------------------------------------------------------------------
module fpaic_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  fpaic_pkg::s2_type in_data,
   output logic              out_valid,
   output logic [31:0]       out_bits
);
   logic [4:0]  p;
   logic [31:0] frac_sh;
   logic [7:0]  e;
   logic [31:0] res_in, res_ff;
   logic        valid_ff;

   always_comb begin
      p = fpaic_pkg::lead_one(in_data.mag);
      if (p > 5'd23) frac_sh = in_data.mag >> (p - 5'd23);
      else           frac_sh = in_data.mag << (5'd23 - p);
      e = '0;
      unique case (in_data.mode)
         fpaic_pkg::MODE_ADD: e = in_data.exp + 8'(p) - 8'd23;
         fpaic_pkg::MODE_MUL: e = in_data.exp;
         fpaic_pkg::MODE_CVT: e = 8'(p) + fpaic_pkg::Bias;
         default:             e = '0;
      endcase
      res_in = {in_data.sign, e, frac_sh[22:0]};
      if (in_data.zero || in_data.mode == fpaic_pkg::MODE_NONE) res_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_bits  = res_ff;
endmodule

/* src/fp32_add_mul_int_convert.sv */
// ----------------------------------------------------------------------------
// fp32_add_mul_int_convert
// Simplified single-precision add, multiply and integer-to-float pipeline.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)              | tuser
// req     | in  | operand_a[31:0], operand_b[63:32] | mode[1:0]
// rsp     | out | result_bits[31:0]               | -
//
// One word per cycle unless the output stalls. Stages: align/multiply,
// normalise product, leading-one shift and pack. The whole pipe
// advances when the output register is empty or being taken, so a stall
// holds every stage. Reset clears the stage valid bits only.
module fp32_add_mul_int_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a, operand_b
   input  logic [1:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // result_bits
);
   logic advance, v1, v2;
   fpaic_pkg::s1_type d1;
   fpaic_pkg::s2_type d2;

   assign advance    = rsp_tready || !rsp_tvalid;
   assign req_tready = advance;

   fpaic_front u_front (
      .clock, .reset, .advance,
      .in_valid (req_tvalid),
      .in_mode  (fpaic_pkg::mode_type'(req_tuser)),
      .in_a     (req_tdata[31:0]),
      .in_b     (req_tdata[63:32]),
      .out_valid(v1),
      .out_data (d1)
   );

   fpaic_mid u_mid (
      .clock, .reset, .advance,
      .in_valid (v1), .in_data (d1),
      .out_valid(v2), .out_data(d2)
   );

   fpaic_back u_back (
      .clock, .reset, .advance,
      .in_valid (v2), .in_data (d2),
      .out_valid(rsp_tvalid), .out_bits(rsp_tdata)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped during stall");
   a_pass: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1)
      else $error("accepted word lost at stage one");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v1) && $stable(v2))
      else $error("pipe moved during stall");
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the fp32 add/multiply/convert pipeline. Operation
// words go in through a bursty sender, results come back through a stalling
// receiver, and every result word is checked against a local prediction of
// the truncating, wrapping arithmetic.
// ----------------------------------------------------------------------------
module tb;
   import fpaic_pkg::*;

   localparam int unsigned CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // operand_a[31:0], operand_b[63:32]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // result_bits[31:0]

   logic [31:0] expected_results[$];
   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned burst_left;

   fp32_add_mul_int_convert uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned top_one(input logic [31:0] v);
      int unsigned p;
      p = 0;
      for (int i = 0; i < 32; i++) if (v[i]) p = i;
      return p;
   endfunction

   function automatic logic [22:0] frac_under(input logic [31:0] v, input int unsigned p);
      logic [31:0] t;
      if (p > 23) t = v >> (p - 23);
      else t = v << (23 - p);
      return t[22:0];
   endfunction

   function automatic logic [31:0] fp_sum(input logic [31:0] a, input logic [31:0] b);
      logic [7:0]  ea, eb, e;
      logic [31:0] ma, mb, mr, d;
      logic        sr;
      int unsigned p;
      ea = a[30:23];
      eb = b[30:23];
      ma = {8'd0, 1'b1, a[22:0]};
      mb = {8'd0, 1'b1, b[22:0]};
      if (ea > eb) begin
         d = ea - eb;
         mb = (d >= 32) ? 32'd0 : mb >> d;
         e = ea;
      end else begin
         d = eb - ea;
         ma = (d >= 32) ? 32'd0 : ma >> d;
         e = eb;
      end
      if (a[31] == b[31]) mr = ma + mb;
      else mr = (ma > mb) ? ma - mb : mb - ma;
      sr = (ma > mb) ? a[31] : b[31];
      if (mr == 0) return 32'd0;
      p = top_one(mr);
      e = 8'(e + p - 23);
      return {sr, e, frac_under(mr, p)};
   endfunction

   function automatic logic [31:0] fp_product(input logic [31:0] a, input logic [31:0] b);
      logic [47:0] prod;
      logic [7:0]  e;
      prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
      e = 8'(a[30:23] + b[30:23] - 127);
      if (prod[47]) begin
         prod = prod >> 24;
         e = e + 8'd1;
      end else begin
         prod = prod >> 23;
      end
      return {a[31] ^ b[31], e, prod[22:0]};
   endfunction

   function automatic logic [31:0] int_to_fp(input logic [31:0] n);
      logic [31:0] mag;
      int unsigned p;
      mag = n[31] ? -n : n;
      if (mag == 0) return 32'd0;
      p = top_one(mag);
      return {n[31], 8'(p + 127), frac_under(mag, p)};
   endfunction

   function automatic logic [31:0] fp_result(input mode_type m, input logic [31:0] a,
                                             input logic [31:0] b);
      case (m)
         MODE_ADD: return fp_sum(a, b);
         MODE_MUL: return fp_product(a, b);
         MODE_CVT: return int_to_fp(a);
         default:  return 32'd0;
      endcase
   endfunction

   // bursty sender: one word per call, gaps between bursts
   task automatic send_word(input mode_type m, input logic [31:0] a, input logic [31:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= m;
      expected_results.push_back(fp_result(m, a, b));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_float(input logic [7:0] elo, input logic [7:0] ehi);
      return {1'($urandom), 8'($urandom_range(elo, ehi)), 23'($urandom)};
   endfunction

   task automatic test_directed;
      send_word(MODE_ADD, 32'h3F80_0000, 32'h3F80_0000);
      send_word(MODE_ADD, 32'h3F80_0000, 32'hBF80_0000);
      send_word(MODE_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_word(MODE_ADD, 32'h0000_0000, 32'h0000_0000);
      send_word(MODE_ADD, 32'h7F80_0000, 32'h0000_0001);
      send_word(MODE_ADD, 32'h4000_0000, 32'hBFFF_FFFF);
      send_word(MODE_ADD, 32'h4B80_0000, 32'h3F80_0000);
      send_word(MODE_ADD, 32'h3F80_0000, 32'h4C00_0000);
      send_word(MODE_MUL, 32'h3F80_0000, 32'h3F80_0000);
      send_word(MODE_MUL, 32'h3FFF_FFFF, 32'hBFFF_FFFF);
      send_word(MODE_MUL, 32'h7F80_0000, 32'h7F80_0000);
      send_word(MODE_MUL, 32'h0000_0000, 32'h0000_0000);
      send_word(MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(MODE_CVT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(MODE_CVT, 32'h8000_0000, 32'h0);
      send_word(MODE_CVT, 32'h7FFF_FFFF, 32'h0);
      send_word(MODE_CVT, 32'hFFFF_FFFF, 32'h0);
      send_word(MODE_CVT, 32'h0000_0001, 32'h0);
      send_word(MODE_CVT, 32'h00FF_FFFF, 32'h0);
      send_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random;
      logic [31:0] a, b;
      int unsigned sel;
      for (int i = 0; i < 700; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            // near exponents exercise cancellation and carry
            a = rand_float(0, 255);
            b = rand_float(8'(a[30:23] - 2), 8'(a[30:23] - 2));
            b[30:23] = a[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
            if (sel == 0) b[30:0] = a[30:0] ^ 31'($urandom_range(0, 3));
         end else begin
            a = $urandom;
            b = $urandom;
         end
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: send_word(MODE_ADD, a, b);
            6, 7, 8, 9, 10:   send_word(MODE_MUL, a, b);
            11, 12, 13, 14:   send_word(MODE_CVT, $urandom >> $urandom_range(0, 31), b);
            default:          send_word(MODE_NONE, a, b);
         endcase
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result_bits: none expected, actual %h", rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== expected_results[0]) begin
               $error("result_bits: expected %h, actual %h", expected_results[0], rsp_tdata);
               fail_count++;
            end
            void'(expected_results.pop_front());
         end
      end
   end

   // receiver stall pattern: alternating stall-free and choppy stretches
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b1;
      else if (cycle_count[8]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      fail_count  = 0;
      cycle_count = 0;
      burst_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_ADD;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
